// ===== design/acs_pkg.sv =====
`timescale 1ns / 1ps

package acs_pkg;

  localparam int PC_W    = 11;
  localparam int WORD_W  = 16;
  localparam int ACC_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int FLAG_W  = 4;
  localparam int CODE_W  = 5;
  localparam int IO_AW   = 5;
  localparam int IO_ENTRIES = 32;

  // flag bit positions
  localparam int FLAG_ZERO  = 0;
  localparam int FLAG_CARRY = 1;
  localparam int FLAG_SIGN  = 2;
  localparam int FLAG_OVER  = 3;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_IO_READ = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RUN_ACTIVE  = 2'd0,
    RUN_ENDED   = 2'd1,
    RUN_ILLEGAL = 2'd2
  } run_e;

  typedef enum logic [CODE_W-1:0] {
    OP_WM   = 5'h01,
    OP_RM   = 5'h02,
    OP_BR   = 5'h03,
    OP_RIO  = 5'h04,
    OP_WIO  = 5'h05,
    OP_WB   = 5'h06,
    OP_WIB  = 5'h07,
    OP_WACC = 5'h09,
    OP_RACC = 5'h0B,
    OP_SWAP = 5'h0E,
    OP_BRLT = 5'h11,
    OP_BRGT = 5'h12,
    OP_BRNE = 5'h13,
    OP_BRE  = 5'h14,
    OP_SHR  = 5'h15,
    OP_SHL  = 5'h16,
    OP_XOR  = 5'h17,
    OP_NOT  = 5'h18,
    OP_OR   = 5'h19,
    OP_AND  = 5'h1A,
    OP_MUL  = 5'h1B,
    OP_SUB  = 5'h1D,
    OP_ADD  = 5'h1E,
    OP_EOP  = 5'h1F
  } code_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOST,
    S_READ,
    S_FETCH_LO,
    S_DECODE,
    S_EXEC
  } state_e;

  // architectural registers visible on the result
  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [ACC_W-1:0]  acc;
    logic [BYTE_W-1:0] mbr;
    logic [BYTE_W-1:0] iobr;
    logic [FLAG_W-1:0] flags;
    run_e              run;
  } arch_t;

  function automatic logic [FLAG_W-1:0] flags_of(logic [ACC_W-1:0] v);
    logic [FLAG_W-1:0] f;
    f = '0;
    f[FLAG_ZERO]  = (v == '0);
    f[FLAG_CARRY] = |v[ACC_W-1:BYTE_W];
    f[FLAG_OVER]  = |v[ACC_W-1:BYTE_W];
    f[FLAG_SIGN]  = v[BYTE_W-1];
    return f;
  endfunction

endpackage

// ===== design/acs_ram.sv =====
`timescale 1ns / 1ps

module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/acs_alu.sv =====
`timescale 1ns / 1ps

module acs_alu import acs_pkg::*; (
  input  logic [WORD_W-1:0] ir_i,
  input  arch_t             arch_i,
  input  logic [BYTE_W-1:0] mem_data_i,
  input  logic [BYTE_W-1:0] io_data_i,
  output arch_t             arch_o
);

  code_e             code;
  logic [PC_W-1:0]   op;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] a8;
  logic [23:0]       prod;
  logic [ACC_W-1:0]  diff;
  logic [FLAG_W-1:0] cmp_f;
  logic [ACC_W-1:0]  logic_res;
  logic              take;

  assign code  = code_e'(ir_i[WORD_W-1:PC_W]);
  assign op    = ir_i[PC_W-1:0];
  assign b     = arch_i.mbr;
  assign a8    = arch_i.acc[BYTE_W-1:0];
  assign prod  = arch_i.acc * b;
  assign diff  = arch_i.acc - {8'd0, b};
  assign cmp_f = flags_of(diff);

  always_comb begin
    arch_o    = arch_i;
    logic_res = '0;
    take      = 1'b0;
    unique case (code)
      OP_WM, OP_WIO: ;
      OP_RM:   arch_o.mbr  = mem_data_i;
      OP_BR:   arch_o.pc   = op;
      OP_RIO:  arch_o.iobr = io_data_i;
      OP_WB:   arch_o.mbr  = op[BYTE_W-1:0];
      OP_WIB:  arch_o.iobr = op[BYTE_W-1:0];
      OP_WACC: begin
        arch_o.acc   = {8'd0, b};
        arch_o.flags = '0;
      end
      OP_RACC: begin
        arch_o.mbr   = a8;
        arch_o.flags = '0;
      end
      OP_SWAP: begin
        arch_o.mbr  = arch_i.iobr;
        arch_o.iobr = arch_i.mbr;
      end
      OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE: begin
        arch_o.acc   = {8'd0, diff[BYTE_W-1:0]};
        arch_o.flags = cmp_f;
        take = (code == OP_BRE  &&  cmp_f[FLAG_ZERO]) ||
               (code == OP_BRNE && !cmp_f[FLAG_ZERO]) ||
               (code == OP_BRGT && !cmp_f[FLAG_SIGN]) ||
               (code == OP_BRLT &&  cmp_f[FLAG_SIGN]);
        if (take) begin
          arch_o.pc = op;
        end
      end
      OP_SHR: begin
        arch_o.flags = '0;
        arch_o.flags[FLAG_CARRY] = arch_i.acc[0];
        arch_o.acc = {8'd0, arch_i.acc[BYTE_W:1]};
      end
      OP_SHL: begin
        arch_o.flags = '0;
        arch_o.flags[FLAG_CARRY] = arch_i.acc[BYTE_W-1];
        arch_o.acc = {8'd0, arch_i.acc[BYTE_W-2:0], 1'b0};
      end
      OP_XOR, OP_NOT, OP_OR, OP_AND, OP_SUB, OP_ADD: begin
        unique case (code)
          OP_XOR:  logic_res = {8'd0, a8 ^ b};
          OP_NOT:  logic_res = {8'd0, ~a8};
          OP_OR:   logic_res = {8'd0, a8 | b};
          OP_AND:  logic_res = {8'd0, a8 & b};
          OP_SUB:  logic_res = {8'd0, a8 - b};
          default: logic_res = {8'd0, a8 + b};
        endcase
        arch_o.acc   = logic_res;
        arch_o.flags = flags_of(logic_res);
      end
      OP_MUL: begin
        arch_o.acc   = prod[ACC_W-1:0];
        arch_o.flags = flags_of(prod[ACC_W-1:0]);
      end
      OP_EOP:  arch_o.run = RUN_ENDED;
      default: arch_o.run = RUN_ILLEGAL;
    endcase
  end

endmodule

// ===== design/accumulator_cpu_step_top.sv =====
`timescale 1ns / 1ps

// channel | valid      | stall       | payload
// --------+------------+-------------+------------------------------------------------
// input   | in_valid_i | in_stall_o  | opcode_i, address_i, data_i
// output  | out_valid_o| out_stall_i | read_data_o, prog_counter_o, instr_word_o,
//         |            |             | accumulator_out_o, buffer_byte_o, io_byte_o,
//         |            |             | flag_bits_o, run_state_o
//
// an instruction step runs high byte fetch, low byte fetch, decode with the data
//   access, then execute; the single port of the main store makes these steps sequential
// host writes and steps while halted finish from S_HOST, host reads from S_READ
// after reset a clearing pass zeroes both stores, input stalled
// one transaction is in flight at a time; the next one is taken while a result
//   still waits in the output register, and finishes once that register is free

module accumulator_cpu_step_top import acs_pkg::*; #(
  parameter int MEM_DEPTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [PC_W-1:0]   address_i,
  input  logic [BYTE_W-1:0] data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] read_data_o,
  output logic [PC_W-1:0]   prog_counter_o,
  output logic [WORD_W-1:0] instr_word_o,
  output logic [ACC_W-1:0]  accumulator_out_o,
  output logic [BYTE_W-1:0] buffer_byte_o,
  output logic [BYTE_W-1:0] io_byte_o,
  output logic [FLAG_W-1:0] flag_bits_o,
  output logic [1:0]        run_state_o
);

  localparam int AW = $clog2(MEM_DEPTH);

  // address modulo depth, for quotients up to seven: compare against
  // every multiple in parallel and keep the largest that fits
  function automatic logic [AW-1:0] mem_idx(logic [PC_W-1:0] a);
    logic [PC_W-1:0] r;
    r = a;
    for (int k = 1; k < 8; k++) begin
      if (int'(a) >= k * MEM_DEPTH) begin
        r = a - PC_W'(k * MEM_DEPTH);
      end
    end
    return AW'(r);
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0]     clr_cnt_q;
  cmd_e              cmd_q;
  logic [BYTE_W-1:0] hi_q;
  logic [WORD_W-1:0] ir_q;
  arch_t             arch_q;

  // output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_rd_q;
  logic [WORD_W-1:0] out_ir_q;
  arch_t             out_arch_q;

  // memory ports
  logic              main_we, main_re;
  logic [AW-1:0]     main_addr;
  logic [BYTE_W-1:0] main_wdata, main_rdata;
  logic              io_we, io_re;
  logic [IO_AW-1:0]  io_addr;
  logic [BYTE_W-1:0] io_wdata, io_rdata;

  logic              accept;
  logic              out_free;
  logic              finish;
  logic [BYTE_W-1:0] fin_rd;
  arch_t             fin_arch;
  arch_t             alu_arch;
  logic [WORD_W-1:0] word;
  code_e             dec_code;
  logic [PC_W-1:0]   dec_op;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign word     = {hi_q, main_rdata};
  assign dec_code = code_e'(word[WORD_W-1:PC_W]);
  assign dec_op   = word[PC_W-1:0];

  acs_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_DEPTH)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .re_i    (main_re),
    .addr_i  (main_addr),
    .wdata_i (main_wdata),
    .rdata_o (main_rdata)
  );

  acs_ram #(.WIDTH(BYTE_W), .DEPTH(IO_ENTRIES)) u_io_ram (
    .clk_i   (clk_i),
    .we_i    (io_we),
    .re_i    (io_re),
    .addr_i  (io_addr),
    .wdata_i (io_wdata),
    .rdata_o (io_rdata)
  );

  // execute stage works on the latched word and the data read in decode
  acs_alu u_alu (
    .ir_i       (ir_q),
    .arch_i     (arch_q),
    .mem_data_i (main_rdata),
    .io_data_i  (io_rdata),
    .arch_o     (alu_arch)
  );

  always_comb begin
    state_d    = state_q;
    main_we    = 1'b0;
    main_re    = 1'b0;
    main_addr  = '0;
    main_wdata = '0;
    io_we      = 1'b0;
    io_re      = 1'b0;
    io_addr    = '0;
    io_wdata   = '0;
    finish     = 1'b0;
    fin_rd     = '0;
    fin_arch   = arch_q;
    unique case (state_q)
      S_CLEAR: begin
        // zero both stores, io store rides along on the low counter bits
        main_we   = 1'b1;
        main_addr = clr_cnt_q;
        io_we     = 1'b1;
        io_addr   = clr_cnt_q[IO_AW-1:0];
        if (clr_cnt_q == AW'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(opcode_i))
            CMD_WRITE: begin
              main_we    = 1'b1;
              main_addr  = mem_idx(address_i);
              main_wdata = data_i;
              state_d    = S_HOST;
            end
            CMD_STEP: begin
              if (arch_q.run != RUN_ACTIVE) begin
                state_d = S_HOST;
              end else begin
                main_re   = 1'b1;
                main_addr = mem_idx(arch_q.pc);
                state_d   = S_FETCH_LO;
              end
            end
            CMD_READ: begin
              main_re   = 1'b1;
              main_addr = mem_idx(address_i);
              state_d   = S_READ;
            end
            CMD_IO_READ: begin
              io_re   = 1'b1;
              io_addr = address_i[IO_AW-1:0];
              state_d = S_READ;
            end
          endcase
        end
      end
      S_HOST: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        // read data holds in the ram until the result can leave
        if (out_free) begin
          finish  = 1'b1;
          fin_rd  = (cmd_q == CMD_READ) ? main_rdata : io_rdata;
          state_d = S_IDLE;
        end
      end
      S_FETCH_LO: begin
        main_re   = 1'b1;
        main_addr = mem_idx(arch_q.pc + 11'd1);
        state_d   = S_DECODE;
      end
      S_DECODE: begin
        // the one data access of the instruction
        unique case (dec_code)
          OP_WM: begin
            main_we    = 1'b1;
            main_addr  = mem_idx(dec_op);
            main_wdata = arch_q.mbr;
          end
          OP_RM: begin
            main_re   = 1'b1;
            main_addr = mem_idx(dec_op);
          end
          OP_RIO: begin
            io_re   = 1'b1;
            io_addr = dec_op[IO_AW-1:0];
          end
          OP_WIO: begin
            io_we    = 1'b1;
            io_addr  = dec_op[IO_AW-1:0];
            io_wdata = arch_q.iobr;
          end
          default: ;
        endcase
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          finish   = 1'b1;
          fin_arch = alu_arch;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      cmd_q       <= CMD_WRITE;
      ir_q        <= '0;
      arch_q      <= '{pc: '0, acc: '0, mbr: '0, iobr: '0, flags: '0, run: RUN_ACTIVE};
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (accept) begin
        cmd_q <= cmd_e'(opcode_i);
      end
      if (state_q == S_DECODE) begin
        ir_q      <= word;
        arch_q.pc <= arch_q.pc + 11'd2;
      end
      if (finish) begin
        arch_q <= fin_arch;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a transaction completes; hi_q takes the fetched high byte
  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH_LO) begin
      hi_q <= main_rdata;
    end
    if (finish) begin
      out_rd_q   <= fin_rd;
      out_ir_q   <= ir_q;
      out_arch_q <= fin_arch;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_rd_q;
  assign prog_counter_o    = out_arch_q.pc;
  assign instr_word_o      = out_ir_q;
  assign accumulator_out_o = out_arch_q.acc;
  assign buffer_byte_o     = out_arch_q.mbr;
  assign io_byte_o         = out_arch_q.iobr;
  assign flag_bits_o       = out_arch_q.flags;
  assign run_state_o       = out_arch_q.run;

  // a halted core stays halted
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arch_q.run != RUN_ACTIVE) |=> (arch_q.run == $past(arch_q.run)))
    else $error("halt state left without reset");

  // a step while halted must not move the program counter
  a_halted_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == CMD_STEP && arch_q.run != RUN_ACTIVE) |=> $stable(arch_q.pc))
    else $error("program counter moved on halted step");

  // write and step results carry no read byte
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (cmd_q == CMD_WRITE || cmd_q == CMD_STEP)) |=> (read_data_o == '0))
    else $error("read byte on non-read result");

  // nothing leaves while the stores are being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q)
    else $error("result during clearing pass");

  // a completed transaction always returns to idle
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle");

endmodule
